/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the tile matcher RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk_i outside reset.
`define ASSERT_CLKD(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/core/mttm_pkg.sv */
// ----------------------------------------------------------------------------
// mttm_pkg
// Types, widths and constants shared by the tile matcher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mttm_pkg;

  localparam int DEF_NUM_TEMPLATES = 16;
  localparam int DEF_TILE_PIXELS   = 2048;

  localparam int SEL_W   = 4;
  localparam int PIX_W   = 11;
  localparam int CHAN_W  = 8;
  localparam int THR_W   = 9;
  localparam int TIU_W   = 5;
  localparam int IDX_W   = 4;
  localparam int ENTRY_W = 1 + 3 * CHAN_W;

  // Only templates below this count can be named by the result index.
  localparam int INDEX_LIMIT = 16;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CHAN_W-1:0] OPAQUE_ALPHA    = 8'hFF;
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 9'd3;
  localparam logic [TIU_W-1:0]  IN_USE_RESET    = 5'd0;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_CMP  = 1'b1
  } mttm_mode_e;

  typedef enum logic {
    CFG_THRESHOLD = 1'b0,
    CFG_IN_USE    = 1'b1
  } mttm_cfg_e;

  // One pixel transaction plus the running search result riding with it.
  typedef struct packed {
    mttm_mode_e        mode;
    logic [SEL_W-1:0]  sel;
    logic [PIX_W-1:0]  pix;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              last;
    logic              found;
    logic [IDX_W-1:0]  idx;
  } mttm_item_t;

  function automatic logic [CHAN_W-1:0] chan_diff(input logic [CHAN_W-1:0] x,
                                                   input logic [CHAN_W-1:0] y);
    chan_diff = (x > y) ? (x - y) : (y - x);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/mttm_ram.sv */
// ----------------------------------------------------------------------------
// mttm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mttm_ram #(
  parameter  int WIDTH = 1,
  parameter  int DEPTH = 2,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mttm_cell.sv */
// ----------------------------------------------------------------------------
// mttm_cell
// One template of the library: its pixel RAM, its match flag and one stage
// of the chain that carries pixels and the running search result.
// ----------------------------------------------------------------------------
`default_nettype none

module mttm_cell #(
  parameter int CELL_IDX    = 0,
  parameter int TILE_PIXELS = mttm_pkg::DEF_TILE_PIXELS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic                          in_valid_i,
  input  wire mttm_pkg::mttm_item_t          in_item_i,
  input  wire logic [mttm_pkg::THR_W-1:0]    thresh_i,
  input  wire logic [mttm_pkg::TIU_W-1:0]    in_use_i,
  output logic                               out_valid_o,
  output mttm_pkg::mttm_item_t               out_item_o
);

  import mttm_pkg::*;

  localparam int AddrW = (TILE_PIXELS > 1) ? $clog2(TILE_PIXELS) : 1;

  logic                      valid_q;
  mttm_item_t                item_q;
  logic                      flag_q, flag_d;
  logic [PIX_W+AddrW-1:0]    in_pix_ext;
  logic [AddrW-1:0]          in_addr;
  logic                      in_rng;
  logic                      wr_en;
  logic [ENTRY_W-1:0]        wr_entry;
  logic [ENTRY_W-1:0]        entry;
  logic                      cur_rng;
  logic                      is_cmp;
  logic                      report;
  logic                      chan_ok;
  logic                      miss;
  logic                      hit_now;
  logic                      eligible;

  // Issue the RAM access as the transaction enters; data lines up with item_q.
  assign in_pix_ext = {{AddrW{1'b0}}, in_item_i.pix};
  assign in_addr    = in_pix_ext[AddrW-1:0];
  assign in_rng     = (32'(in_item_i.pix) < TILE_PIXELS);
  assign wr_en      = adv_i && in_valid_i && (in_item_i.mode == MODE_LOAD) && in_rng &&
                      (32'(in_item_i.sel) == CELL_IDX);
  assign wr_entry   = {(in_item_i.alpha == OPAQUE_ALPHA), in_item_i.red,
                       in_item_i.green, in_item_i.blue};

  mttm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TILE_PIXELS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(in_addr),
    .wdata_i(wr_entry),
    .re_i   (adv_i),
    .raddr_i(in_addr),
    .rdata_o(entry)
  );

  assign cur_rng = (32'(item_q.pix) < TILE_PIXELS);
  assign is_cmp  = valid_q && (item_q.mode == MODE_CMP);
  assign report  = is_cmp && item_q.last;
  assign chan_ok =
    ({1'b0, chan_diff(entry[3*CHAN_W-1:2*CHAN_W], item_q.red)}   < thresh_i) &&
    ({1'b0, chan_diff(entry[2*CHAN_W-1:CHAN_W],   item_q.green)} < thresh_i) &&
    ({1'b0, chan_diff(entry[CHAN_W-1:0],          item_q.blue)}  < thresh_i);
  // Transparent template pixels never clear the flag.
  assign miss     = is_cmp && cur_rng && entry[ENTRY_W-1] && !chan_ok;
  assign hit_now  = flag_q && !miss;
  assign eligible = (CELL_IDX < INDEX_LIMIT) && (32'(in_use_i) > CELL_IDX);

  always_comb begin
    flag_d = flag_q;
    if (adv_i) begin
      priority if (report) begin
        flag_d = 1'b1;
      end else if (miss) begin
        flag_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_item_o = item_q;
    if (report && !item_q.found && hit_now && eligible) begin
      out_item_o.found = 1'b1;
      out_item_o.idx   = IDX_W'(CELL_IDX);
    end
  end

  assign out_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      flag_q  <= 1'b1;
    end else begin
      flag_q <= flag_d;
      if (adv_i) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/masked_tile_template_matcher.sv */
// ----------------------------------------------------------------------------
// masked_tile_template_matcher
// Matches a streamed tile against a library of masked template tiles held
// in a chain of per-template cells.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Transaction
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | template pixel load or tile pixel compare
//  m_axis   | out       | match report, one per compare pixel marked tlast
//  cfg      | in        | register write: threshold or templates in use
//
//  Sustained rate is one pixel per cycle while the report register is not
//  blocked; a report passes one item register per cell and then the report
//  register; the template RAM read in each cell is issued as the transaction
//  enters and lines up with that cell's item register.
//  Reset sets all match flags, threshold 3 and zero templates in use; the
//  template RAMs are not cleared.
//  A full output register not taken freezes the whole chain and drops
//  s_axis_tready until it drains.
//
`default_nettype none

module masked_tile_template_matcher #(
  parameter int NUM_TEMPLATES = mttm_pkg::DEF_NUM_TEMPLATES,
  parameter int TILE_PIXELS   = mttm_pkg::DEF_TILE_PIXELS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // tdata: template_sel[3:0], pixel_index[14:4], red[22:15], green[30:23],
  //        blue[38:31], alpha[46:39], zero[47]
  input  wire logic [mttm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tuser: mode[0]
  input  wire logic                              s_axis_tuser,
  input  wire logic                              s_axis_tlast,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: matched[0], template_index[4:1], zero[7:5]
  output logic [mttm_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire mttm_pkg::mttm_cfg_e               cfg_index_i,
  input  wire logic [mttm_pkg::THR_W-1:0]        cfg_data_i
);

  import mttm_pkg::*;

  logic [THR_W-1:0] thresh_q;
  logic [TIU_W-1:0] in_use_q;
  logic             adv;
  logic             chain_valid [NUM_TEMPLATES+1];
  mttm_item_t       chain_item  [NUM_TEMPLATES+1];
  mttm_item_t       tail;
  logic             tail_report;
  logic             out_valid_q, out_valid_d;
  logic             out_matched_q;
  logic [IDX_W-1:0] out_idx_q;

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESHOLD_RESET;
      in_use_q <= IN_USE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD: thresh_q <= cfg_data_i;
        CFG_IN_USE:    in_use_q <= cfg_data_i[TIU_W-1:0];
        default:       ;
      endcase
    end
  end

  // Whole chain moves together; hold it while the report register is blocked.
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_comb begin
    chain_item[0]       = '0;
    chain_item[0].mode  = mttm_mode_e'(s_axis_tuser);
    chain_item[0].sel   = s_axis_tdata[3:0];
    chain_item[0].pix   = s_axis_tdata[14:4];
    chain_item[0].red   = s_axis_tdata[22:15];
    chain_item[0].green = s_axis_tdata[30:23];
    chain_item[0].blue  = s_axis_tdata[38:31];
    chain_item[0].alpha = s_axis_tdata[46:39];
    chain_item[0].last  = s_axis_tlast;
  end
  assign chain_valid[0] = s_axis_tvalid;

  for (genvar k = 0; k < NUM_TEMPLATES; k++) begin : g_cell
    mttm_cell #(
      .CELL_IDX   (k),
      .TILE_PIXELS(TILE_PIXELS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .in_valid_i (chain_valid[k]),
      .in_item_i  (chain_item[k]),
      .thresh_i   (thresh_q),
      .in_use_i   (in_use_q),
      .out_valid_o(chain_valid[k+1]),
      .out_item_o (chain_item[k+1])
    );
  end

  assign tail        = chain_item[NUM_TEMPLATES];
  assign tail_report = chain_valid[NUM_TEMPLATES] && (tail.mode == MODE_CMP) && tail.last;

  // Report register; non-report transactions drop off the chain end.
  assign out_valid_d = adv ? tail_report : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && tail_report) begin
      out_matched_q <= tail.found;
      out_idx_q     <= tail.found ? tail.idx : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_idx_q, out_matched_q};

  `include "assert_macros.svh"

  `ASSERT_CLKD(a_stall_blocks_input,
               (out_valid_q && !m_axis_tready) |-> !s_axis_tready,
               "input taken while report blocked")
  `ASSERT_CLKD(a_index_in_use,
               (out_valid_q && out_matched_q) |-> ({1'b0, out_idx_q} < in_use_q),
               "reported template not in use")
  `ASSERT_CLKD(a_nomatch_zero,
               (out_valid_q && !out_matched_q) |-> (out_idx_q == '0),
               "index nonzero without match")
  `ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid, "report valid after reset")

endmodule

`default_nettype wire
